// ===== rtl/fot_pkg.sv =====
// ----------------------------------------------------------------------------
// fot_pkg
// types, constants and commands shared by the flow origin tracker modules
// ----------------------------------------------------------------------------
package fot_pkg;

  localparam int TCP_FLOWS = 16;
  localparam int UDP_FLOWS = 16;
  localparam int TCP_IDX_W = (TCP_FLOWS > 1) ? $clog2(TCP_FLOWS) : 1;
  localparam int UDP_IDX_W = (UDP_FLOWS > 1) ? $clog2(UDP_FLOWS) : 1;
  localparam int SCAN_W    = ((TCP_FLOWS > UDP_FLOWS) ? TCP_IDX_W : UDP_IDX_W) + 1;

  localparam logic [31:0] TCP_ORIGIN_BASE = 32'd1;
  localparam logic [31:0] UDP_ORIGIN_BASE = 32'd65536;

  localparam logic [15:0] ETHER_IPV4  = 16'h0800;
  localparam logic [7:0]  PROTO_TCP   = 8'd6;
  localparam logic [7:0]  PROTO_UDP   = 8'd17;
  localparam logic [6:0]  ETH_IP_HDR  = 7'd34;
  localparam logic [6:0]  UDP_HDR_LEN = 7'd42;
  localparam logic [16:0] ETH_HDR     = 17'd14;
  localparam logic [16:0] UDP_IP_HDR  = 17'd28;

  typedef enum logic [2:0] {
    CFG_TAINT_EN   = 3'd0,
    CFG_FILTER_EN  = 3'd1,
    CFG_PROTO      = 3'd2,
    CFG_SRC_PORT   = 3'd3,
    CFG_DST_PORT   = 3'd4,
    CFG_SRC_ADDR   = 3'd5,
    CFG_DST_ADDR   = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN1,
    ST_UPSERT,
    ST_SCAN2,
    ST_FINISH,
    ST_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture item
    logic scan_clr;   // restart scan
    logic scan_step;  // examine one entry of each table
    logic upsert;     // perform tcp insert/update
    logic finish;     // compute result, apply fin and udp insert
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic is_sent;    // sent frame needing tcp upsert
    logic do_tcp;     // received tcp, eligible
    logic do_udp;     // received udp, eligible
    logic synack;
  } dp_sts_t;

endpackage

// ===== rtl/fot_ctrl.sv =====
// ----------------------------------------------------------------------------
// fot_ctrl
// sequencer: capture, table scans, update and result handshake
// ----------------------------------------------------------------------------
module fot_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output fot_pkg::dp_cmd_t cmd,
  input  fot_pkg::dp_sts_t sts
);

  fot_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fot_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      fot_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load     = 1'b1;
          cmd.scan_clr = 1'b1;
          state_nxt    = fot_pkg::ST_SCAN1;
        end
      end
      fot_pkg::ST_SCAN1: begin
        // scan results stay for the upsert or finish step
        if (sts.scan_done) begin
          if ((sts.is_sent || (sts.do_tcp && sts.synack))) begin
            state_nxt = fot_pkg::ST_UPSERT;
          end else begin
            state_nxt = fot_pkg::ST_FINISH;
          end
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      fot_pkg::ST_UPSERT: begin
        cmd.upsert   = 1'b1;
        cmd.scan_clr = 1'b1;
        // a received synack rescans to find the flow it just wrote
        state_nxt = sts.do_tcp ? fot_pkg::ST_SCAN2 : fot_pkg::ST_FINISH;
      end
      fot_pkg::ST_SCAN2: begin
        if (sts.scan_done) begin
          state_nxt = fot_pkg::ST_FINISH;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      fot_pkg::ST_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = fot_pkg::ST_OUT;
      end
      fot_pkg::ST_OUT: begin
        out_valid = 1'b1;
        in_ready  = out_ready;
        if (out_ready) begin
          if (in_valid) begin
            cmd.load     = 1'b1;
            cmd.scan_clr = 1'b1;
            state_nxt    = fot_pkg::ST_SCAN1;
          end else begin
            state_nxt = fot_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = fot_pkg::ST_IDLE;
    endcase
  end

  a_finish_then_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid) else $error("result not presented after finish");
  a_no_load_midwork: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan_step || cmd.upsert) |-> !in_ready) else $error("ready during work");
  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");

endmodule

// ===== rtl/fot_dp.sv =====
// ----------------------------------------------------------------------------
// fot_dp
// flow tables, serial lookup and result formatting
// ----------------------------------------------------------------------------
module fot_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  fot_pkg::dp_cmd_t cmd,
  output fot_pkg::dp_sts_t sts,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_addr,
  input  logic [31:0]      cfg_wdata,
  input  logic             in_op,
  input  logic [15:0]      in_ether_type,
  input  logic [7:0]       in_ip_proto,
  input  logic [31:0]      in_src_addr,
  input  logic [31:0]      in_dst_addr,
  input  logic [15:0]      in_src_port,
  input  logic [15:0]      in_dst_port,
  input  logic [7:0]       in_tcp_flag_bits,
  input  logic [31:0]      in_tcp_seq_num,
  input  logic [31:0]      in_tcp_ack_num,
  input  logic [15:0]      in_ip_total_len,
  input  logic [3:0]       in_tcp_hdr_words,
  output logic             out_tainted,
  output logic [31:0]      out_flow_origin,
  output logic [31:0]      out_offset_base,
  output logic [6:0]       out_header_len,
  output logic [15:0]      out_payload_len,
  output logic             out_table_full
);

  localparam int TN = fot_pkg::TCP_FLOWS;
  localparam int UN = fot_pkg::UDP_FLOWS;
  localparam int TW = fot_pkg::TCP_IDX_W;
  localparam int UW = fot_pkg::UDP_IDX_W;
  localparam int SW = fot_pkg::SCAN_W;

  // configuration
  logic        taint_en_r, filter_en_r;
  logic [7:0]  f_proto_r;
  logic [15:0] f_sp_r, f_dp_r;
  logic [31:0] f_sa_r, f_da_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taint_en_r <= 1'b0; filter_en_r <= 1'b0; f_proto_r <= '0;
      f_sp_r <= '0; f_dp_r <= '0; f_sa_r <= '0; f_da_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        fot_pkg::CFG_TAINT_EN:  taint_en_r  <= cfg_wdata[0];
        fot_pkg::CFG_FILTER_EN: filter_en_r <= cfg_wdata[0];
        fot_pkg::CFG_PROTO:     f_proto_r   <= cfg_wdata[7:0];
        fot_pkg::CFG_SRC_PORT:  f_sp_r      <= cfg_wdata[15:0];
        fot_pkg::CFG_DST_PORT:  f_dp_r      <= cfg_wdata[15:0];
        fot_pkg::CFG_SRC_ADDR:  f_sa_r      <= cfg_wdata;
        fot_pkg::CFG_DST_ADDR:  f_da_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // captured item
  logic        op_r, synack_r, fin_r, ipv4_r;
  logic [7:0]  proto_r;
  logic [15:0] sp_r, dp_r, iplen_r;
  logic [31:0] sa_r, da_r, seq_r, ack_r, id_r;
  logic [3:0]  words_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_op;
      ipv4_r   <= (in_ether_type == fot_pkg::ETHER_IPV4);
      proto_r  <= in_ip_proto;
      sp_r     <= in_src_port;
      dp_r     <= in_dst_port;
      sa_r     <= in_src_addr;
      da_r     <= in_dst_addr;
      synack_r <= in_tcp_flag_bits[1] && in_tcp_flag_bits[4];
      fin_r    <= in_tcp_flag_bits[0];
      seq_r    <= in_tcp_seq_num;
      ack_r    <= in_tcp_ack_num;
      iplen_r  <= in_ip_total_len;
      words_r  <= in_tcp_hdr_words;
      id_r     <= {24'd0, in_ip_proto} ^ {16'd0, in_src_port} ^ {16'd0, in_dst_port}
                  ^ in_src_addr ^ in_dst_addr;
    end
  end

  // eligibility and filter
  logic is_tcp, is_udp, fpass, rx_ok;
  always_comb begin
    is_tcp = (proto_r == fot_pkg::PROTO_TCP);
    is_udp = (proto_r == fot_pkg::PROTO_UDP);
    if ((f_proto_r == fot_pkg::PROTO_TCP && is_tcp) ||
        (f_proto_r == fot_pkg::PROTO_UDP && is_udp)) begin
      if (f_sp_r != '0)      fpass = (f_sp_r == sp_r);
      else if (f_dp_r != '0) fpass = (f_dp_r == dp_r);
      else                   fpass = 1'b1;
    end else begin
      if (f_sa_r != '0)      fpass = (f_sa_r == sa_r);
      else if (f_da_r != '0) fpass = (f_da_r == da_r);
      else                   fpass = 1'b0;
    end
    rx_ok = !op_r && taint_en_r && ipv4_r && (is_tcp || is_udp)
            && (!filter_en_r || fpass);
  end

  assign sts.is_sent = op_r && ipv4_r && is_tcp && synack_r;
  assign sts.do_tcp  = rx_ok && is_tcp;
  assign sts.do_udp  = rx_ok && is_udp;
  assign sts.synack  = synack_r;

  // tables
  logic [TN-1:0] tv_r;
  logic [31:0]   tid_r [TN];
  logic [31:0]   tseq_r[TN];
  logic [31:0]   torg_r[TN];
  logic [UN-1:0] uv_r;
  logic [31:0]   uid_r [UN];
  logic [31:0]   uorg_r[UN];
  logic [31:0]   tnext_r, unext_r;

  // serial scan: one tcp and one udp entry per cycle
  logic [SW-1:0] scan_r;
  logic          thit_r, uhit_r, tfree_f_r, ufree_f_r;
  logic [TW-1:0] thit_idx_r, tfree_r;
  logic [UW-1:0] uhit_idx_r, ufree_r;
  logic [TW-1:0] ts;
  logic [UW-1:0] us;
  logic          t_in, u_in;

  assign ts   = scan_r[TW-1:0];
  assign us   = scan_r[UW-1:0];
  assign t_in = ({{(32-SW){1'b0}}, scan_r} < TN);
  assign u_in = ({{(32-SW){1'b0}}, scan_r} < UN);
  assign sts.scan_done = !t_in && !u_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= '0;
    end else if (cmd.scan_clr) begin
      scan_r <= '0;
    end else if (cmd.scan_step) begin
      scan_r <= scan_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_clr) begin
      thit_r <= 1'b0; uhit_r <= 1'b0; tfree_f_r <= 1'b0; ufree_f_r <= 1'b0;
      thit_idx_r <= '0; uhit_idx_r <= '0; tfree_r <= '0; ufree_r <= '0;
    end else if (cmd.scan_step) begin
      if (t_in) begin
        if (tv_r[ts] && tid_r[ts] == id_r && !thit_r) begin
          thit_r <= 1'b1; thit_idx_r <= ts;
        end
        if (!tv_r[ts] && !tfree_f_r) begin
          tfree_f_r <= 1'b1; tfree_r <= ts;
        end
      end
      if (u_in) begin
        if (uv_r[us] && uid_r[us] == id_r && !uhit_r) begin
          uhit_r <= 1'b1; uhit_idx_r <= us;
        end
        if (!uv_r[us] && !ufree_f_r) begin
          ufree_f_r <= 1'b1; ufree_r <= us;
        end
      end
    end
  end

  // result arithmetic
  logic [6:0]  thlen;
  logic [16:0] tlen_sum;
  logic        tlen_pos, ulen_ne, ulen_pos;
  logic [16:0] iplen_x;
  assign iplen_x  = {1'b0, iplen_r};
  assign thlen    = fot_pkg::ETH_IP_HDR + {1'b0, words_r, 2'b00};
  assign tlen_pos = (iplen_x + fot_pkg::ETH_HDR) > {10'd0, thlen};
  assign tlen_sum = iplen_x + fot_pkg::ETH_HDR - {10'd0, thlen};
  assign ulen_ne  = (iplen_x != fot_pkg::UDP_IP_HDR);
  assign ulen_pos = (iplen_x > fot_pkg::UDP_IP_HDR);

  logic          full_r;
  logic          upd_hit;
  logic [TW-1:0] upd_idx;
  assign upd_hit = thit_r || tfree_f_r;
  assign upd_idx = thit_r ? thit_idx_r : tfree_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tv_r    <= '0;
      uv_r    <= '0;
      tnext_r <= fot_pkg::TCP_ORIGIN_BASE;
      unext_r <= fot_pkg::UDP_ORIGIN_BASE;
    end else begin
      if (cmd.upsert && !thit_r && tfree_f_r) begin
        tv_r[tfree_r] <= 1'b1;
        tnext_r       <= tnext_r + 32'd1;
      end
      if (cmd.finish && sts.do_tcp && thit_r && fin_r) tv_r[thit_idx_r] <= 1'b0;
      if (cmd.finish && sts.do_udp && ulen_ne && !uhit_r && ufree_f_r) begin
        uv_r[ufree_r] <= 1'b1;
        unext_r       <= unext_r + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) full_r <= 1'b0;
    else if (cmd.upsert) full_r <= !upd_hit;
    if (cmd.upsert && upd_hit) begin
      tseq_r[upd_idx] <= op_r ? ack_r : seq_r + 32'd1;
      if (!thit_r) begin
        tid_r[upd_idx]  <= id_r;
        torg_r[upd_idx] <= tnext_r;
      end
    end
    if (cmd.finish && sts.do_udp && ulen_ne && !uhit_r && ufree_f_r) begin
      uid_r[ufree_r]  <= id_r;
      uorg_r[ufree_r] <= unext_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_tainted     <= 1'b0;
      out_flow_origin <= '0;
      out_offset_base <= '0;
      out_header_len  <= '0;
      out_payload_len <= '0;
      out_table_full  <= full_r;
      if (sts.do_tcp && thit_r && tlen_pos) begin
        out_tainted     <= 1'b1;
        out_flow_origin <= torg_r[thit_idx_r];
        out_offset_base <= seq_r - tseq_r[thit_idx_r];
        out_header_len  <= thlen;
        out_payload_len <= tlen_sum[15:0];
      end else if (sts.do_udp && ulen_ne) begin
        if (!uhit_r && !ufree_f_r) out_table_full <= 1'b1;
        if (ulen_pos && (uhit_r || ufree_f_r)) begin
          out_tainted     <= 1'b1;
          out_flow_origin <= uhit_r ? uorg_r[uhit_idx_r] : unext_r;
          out_header_len  <= fot_pkg::UDP_HDR_LEN;
          out_payload_len <= iplen_r - fot_pkg::UDP_IP_HDR[15:0];
        end
      end
    end
  end

  a_upsert_only_tcp: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upsert |-> is_tcp) else $error("upsert on non tcp item");
  a_tnext_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.upsert && !thit_r && tfree_f_r) |=> tnext_r == $past(tnext_r) + 32'd1)
    else $error("tcp origin counter not advanced");
  a_tv_gains_one: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upsert |=> $countones(tv_r) <= $countones($past(tv_r)) + 1)
    else $error("more than one tcp entry inserted");

endmodule

// ===== rtl/flow_origin_tracker_core.sv =====
// ----------------------------------------------------------------------------
// flow_origin_tracker_core
// flow origin tracker: tcp and udp flow tables with origin numbering
// ----------------------------------------------------------------------------
// One parsed frame header enters per item on the in_ channel (valid/ready);
// exactly one result leaves per item on the out_ channel (valid/ready).
// Registers are written through the cfg_ channel (index, data); the user is
// to write them only while idle, the block does not enforce it; indexes past
// the register list are ignored. An item is scanned serially against both
// flow tables (16 entries each), one entry of each table per cycle. A sent
// or eligible received tcp syn-ack then takes an upsert step, a received one
// also a second scan, and a finish step registers the result; the table scan
// sets the rate. A new item is taken in the same cycle the result is taken,
// so no new item is accepted before the last result is taken.
// While out_ready is low the result holds and no new item is accepted.
// Synchronous reset clears all flow entries, the registers and restores
// the origin counters to their base values; no clearing pass is needed.
// ----------------------------------------------------------------------------
module flow_origin_tracker_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [15:0] in_ether_type,
  input  logic [7:0]  in_ip_proto,
  input  logic [31:0] in_src_addr,
  input  logic [31:0] in_dst_addr,
  input  logic [15:0] in_src_port,
  input  logic [15:0] in_dst_port,
  input  logic [7:0]  in_tcp_flag_bits,
  input  logic [31:0] in_tcp_seq_num,
  input  logic [31:0] in_tcp_ack_num,
  input  logic [15:0] in_ip_total_len,
  input  logic [3:0]  in_tcp_hdr_words,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_tainted,
  output logic [31:0] out_flow_origin,
  output logic [31:0] out_offset_base,
  output logic [6:0]  out_header_len,
  output logic [15:0] out_payload_len,
  output logic        out_table_full
);

  fot_pkg::dp_cmd_t cmd;
  fot_pkg::dp_sts_t sts;

  assign cfg_ready = 1'b1;

  fot_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  fot_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_valid),
    .cfg_addr         (cfg_index),
    .cfg_wdata        (cfg_data),
    .in_op            (in_op),
    .in_ether_type    (in_ether_type),
    .in_ip_proto      (in_ip_proto),
    .in_src_addr      (in_src_addr),
    .in_dst_addr      (in_dst_addr),
    .in_src_port      (in_src_port),
    .in_dst_port      (in_dst_port),
    .in_tcp_flag_bits (in_tcp_flag_bits),
    .in_tcp_seq_num   (in_tcp_seq_num),
    .in_tcp_ack_num   (in_tcp_ack_num),
    .in_ip_total_len  (in_ip_total_len),
    .in_tcp_hdr_words (in_tcp_hdr_words),
    .out_tainted      (out_tainted),
    .out_flow_origin  (out_flow_origin),
    .out_offset_base  (out_offset_base),
    .out_header_len   (out_header_len),
    .out_payload_len  (out_payload_len),
    .out_table_full   (out_table_full)
  );

endmodule
